### src/aepq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aepq_pkg
// shared types and codes for the active/expired priority run queue
// ----------------------------------------------------------------------------
package aepq_pkg;

   localparam int IdW    = 8;
   localparam int PrioW  = 4;
   localparam int ReqW   = 2;
   localparam int CntOutW = 7;

   typedef enum logic [ReqW-1:0] {
      REQ_INS_ACTIVE  = 2'd0,
      REQ_INS_EXPIRED = 2'd1,
      REQ_GET         = 2'd2,
      REQ_UNUSED      = 2'd3
   } req_code_type;

   typedef struct packed {
      logic [IdW-1:0]   id;
      logic [PrioW-1:0] prio;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2
   } queue_op_type;

   typedef struct packed {
      queue_op_type op;
      entry_type    entry;
   } queue_cmd_type;

endpackage

### src/aepq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aepq_cell
// one slot of a sorted queue; shifts towards the tail on insert, head on pop
// ----------------------------------------------------------------------------
module aepq_cell (
   input  logic                   clock,
   input  aepq_pkg::queue_cmd_type cmd,
   input  logic                   occupied,
   input  logic                   left_lower,
   input  aepq_pkg::entry_type    left_entry,
   input  aepq_pkg::entry_type    right_entry,
   output logic                   lower,
   output aepq_pkg::entry_type    entry
);

   aepq_pkg::entry_type entry_ff;
   aepq_pkg::entry_type entry_in;

   // empty slots count as lower so the new entry lands at the tail
   assign lower = !occupied || (entry_ff.prio < cmd.entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         aepq_pkg::OP_INSERT: begin
            if (lower) begin
               entry_in = left_lower ? left_entry : cmd.entry;
            end
         end
         aepq_pkg::OP_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### src/aepq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aepq_queue
// row of cells forming one priority-sorted queue, plus its fill count
// ----------------------------------------------------------------------------
module aepq_queue #(
   parameter  int DEPTH = 64,
   localparam int CntW  = $clog2(DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  aepq_pkg::queue_cmd_type cmd,
   output logic [CntW-1:0]         count,
   output logic [CntW-1:0]         count_next,
   output aepq_pkg::entry_type     front
);

   logic [CntW-1:0]     count_ff;
   logic [CntW-1:0]     count_in;
   logic                lower [DEPTH];
   aepq_pkg::entry_type slot  [DEPTH];

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                occ;
         logic                l_lower;
         aepq_pkg::entry_type l_entry;
         aepq_pkg::entry_type r_entry;

         assign occ = CntW'(i) < count_ff;

         if (i == 0) begin : g_head
            assign l_lower = 1'b0;
            assign l_entry = slot[i];
         end else begin : g_body
            assign l_lower = lower[i-1];
            assign l_entry = slot[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign r_entry = slot[i];
         end else begin : g_mid
            assign r_entry = slot[i+1];
         end

         aepq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .occupied    (occ),
            .left_lower  (l_lower),
            .left_entry  (l_entry),
            .right_entry (r_entry),
            .lower       (lower[i]),
            .entry       (slot[i])
         );
      end
   endgenerate

   always_comb begin
      case (cmd.op)
         aepq_pkg::OP_INSERT: count_in = count_ff + CntW'(1);
         aepq_pkg::OP_POP:    count_in = count_ff - CntW'(1);
         default:             count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count      = count_ff;
   assign count_next = count_in;
   assign front      = slot[0];

endmodule

### src/active_expired_priority_queue_top.sv
`timescale 1ns / 1ps
// result: registered; it shows on the rsp channel in the cycle after the request is accepted
// throughput: one request per cycle while rsp_ready holds; each queue is a row of
//   cells that all shift in the same cycle, so an insert or pop is a single shift
// reset: both counts cleared, queue a made active, no result pending;
//   cell contents are not cleared and are only read below the count
// ----------------------------------------------------------------------------
// active_expired_priority_queue_top
// active/expired pair of priority-sorted run queues with get and insert
// requests; roles swap when a get finds the active queue empty
// ----------------------------------------------------------------------------
module active_expired_priority_queue_top #(
   parameter int DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [aepq_pkg::ReqW-1:0]          req_type,
   input  logic [aepq_pkg::IdW-1:0]           req_process_id,
   input  logic [aepq_pkg::PrioW-1:0]         req_entry_prio,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_grant_valid,
   output logic [aepq_pkg::IdW-1:0]           rsp_granted_id,
   output logic [aepq_pkg::PrioW-1:0]         rsp_granted_prio,
   output logic                               rsp_insert_dropped,
   output logic [aepq_pkg::CntOutW-1:0]       rsp_active_count,
   output logic [aepq_pkg::CntOutW-1:0]       rsp_expired_count
);

   localparam int CntW = $clog2(DEPTH + 1);

   // role flag and result register
   logic                         a_active_ff, a_active_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         grant_ff, grant_in;
   aepq_pkg::entry_type          gent_ff, gent_in;
   logic                         drop_ff, drop_in;
   logic [aepq_pkg::CntOutW-1:0] act_cnt_ff, act_cnt_in;
   logic [aepq_pkg::CntOutW-1:0] exp_cnt_ff, exp_cnt_in;

   // queue side
   aepq_pkg::queue_cmd_type cmd_a, cmd_b;
   logic [CntW-1:0]         cnt_a, cnt_b, cnt_a_next, cnt_b_next;
   aepq_pkg::entry_type     front_a, front_b;

   // request decode
   aepq_pkg::req_code_type code;
   aepq_pkg::entry_type    new_entry;
   logic                   fire;
   logic                   swap;
   logic [CntW-1:0]        act_cnt, exp_cnt;
   logic                   ins_to_a, ins_to_b;
   logic                   a_full, b_full;
   logic                   pop_a, pop_b;

   // the result register parts the two sides: a new request is taken when no result
   // is pending or while the previous result is being taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   assign code           = aepq_pkg::req_code_type'(req_type);
   assign new_entry.id   = req_process_id;
   assign new_entry.prio = req_entry_prio;

   assign act_cnt = a_active_ff ? cnt_a : cnt_b;
   assign exp_cnt = a_active_ff ? cnt_b : cnt_a;

   assign a_full = cnt_a == CntW'(DEPTH);
   assign b_full = cnt_b == CntW'(DEPTH);

   always_comb begin
      swap     = 1'b0;
      ins_to_a = 1'b0;
      ins_to_b = 1'b0;
      pop_a    = 1'b0;
      pop_b    = 1'b0;
      drop_in  = 1'b0;
      case (code)
         aepq_pkg::REQ_INS_ACTIVE: begin
            ins_to_a = a_active_ff;
            ins_to_b = !a_active_ff;
         end
         aepq_pkg::REQ_INS_EXPIRED: begin
            ins_to_a = !a_active_ff;
            ins_to_b = a_active_ff;
         end
         aepq_pkg::REQ_GET: begin
            // empty active queue with work waiting: expired becomes active
            swap = (act_cnt == '0) && (exp_cnt != '0);
            if ((a_active_ff ^ swap) && cnt_a != '0) begin
               pop_a = 1'b1;
            end
            if (!(a_active_ff ^ swap) && cnt_b != '0) begin
               pop_b = 1'b1;
            end
         end
         default: begin
            swap = 1'b0;
         end
      endcase
      // an insert into a full queue is dropped and the queue stays as it is
      if ((ins_to_a && a_full) || (ins_to_b && b_full)) begin
         drop_in = 1'b1;
      end
   end

   always_comb begin
      cmd_a.entry = new_entry;
      cmd_b.entry = new_entry;
      cmd_a.op    = aepq_pkg::OP_HOLD;
      cmd_b.op    = aepq_pkg::OP_HOLD;
      if (fire) begin
         if (ins_to_a && !a_full) begin
            cmd_a.op = aepq_pkg::OP_INSERT;
         end else if (pop_a) begin
            cmd_a.op = aepq_pkg::OP_POP;
         end
         if (ins_to_b && !b_full) begin
            cmd_b.op = aepq_pkg::OP_INSERT;
         end else if (pop_b) begin
            cmd_b.op = aepq_pkg::OP_POP;
         end
      end
   end

   aepq_queue #(.DEPTH(DEPTH)) u_queue_a (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd_a),
      .count      (cnt_a),
      .count_next (cnt_a_next),
      .front      (front_a)
   );

   aepq_queue #(.DEPTH(DEPTH)) u_queue_b (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd_b),
      .count      (cnt_b),
      .count_next (cnt_b_next),
      .front      (front_b)
   );

   // result fields, counts reported after the step and in the new roles
   always_comb begin
      a_active_in = a_active_ff;
      grant_in    = pop_a || pop_b;
      gent_in     = '0;
      if (pop_a) begin
         gent_in = front_a;
      end else if (pop_b) begin
         gent_in = front_b;
      end
      if (fire) begin
         a_active_in = a_active_ff ^ swap;
      end
      if (a_active_ff ^ swap) begin
         act_cnt_in = aepq_pkg::CntOutW'(cnt_a_next);
         exp_cnt_in = aepq_pkg::CntOutW'(cnt_b_next);
      end else begin
         act_cnt_in = aepq_pkg::CntOutW'(cnt_b_next);
         exp_cnt_in = aepq_pkg::CntOutW'(cnt_a_next);
      end
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_active_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_active_ff  <= a_active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the result register, loaded with each accepted request
   always_ff @(posedge clock) begin
      if (fire) begin
         grant_ff   <= grant_in;
         gent_ff    <= gent_in;
         drop_ff    <= drop_in;
         act_cnt_ff <= act_cnt_in;
         exp_cnt_ff <= exp_cnt_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_grant_valid    = grant_ff;
   assign rsp_granted_id     = gent_ff.id;
   assign rsp_granted_prio   = gent_ff.prio;
   assign rsp_insert_dropped = drop_ff;
   assign rsp_active_count   = act_cnt_ff;
   assign rsp_expired_count  = exp_cnt_ff;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the active/expired priority run queue: a short
// table of directed requests, then random bursts that fill, drain and mix
// both queues, each result checked against its typed row or a cycle-free queue predictor
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH       = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_REQS = 400;
   localparam int TAIL_START  = 340;
   localparam int LONG_HOLD   = 48;
   localparam int RING_DEPTH  = 16;

   // one result as it should appear on the rsp channel
   typedef struct packed {
      logic                         grant;
      logic [aepq_pkg::IdW-1:0]     id;
      logic [aepq_pkg::PrioW-1:0]   prio;
      logic                         dropped;
      logic [aepq_pkg::CntOutW-1:0] act_cnt;
      logic [aepq_pkg::CntOutW-1:0] exp_cnt;
   } sched_outcome_type;

   // one row of the directed table; typed rows carry their result, others
   // take it from the predictor
   typedef struct packed {
      aepq_pkg::req_code_type     rt;
      logic [aepq_pkg::IdW-1:0]   id;
      logic [aepq_pkg::PrioW-1:0] prio;
      logic                       typed;
      sched_outcome_type          want;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [aepq_pkg::ReqW-1:0]    req_type = '0;
   logic [aepq_pkg::IdW-1:0]     req_process_id = '0;
   logic [aepq_pkg::PrioW-1:0]   req_entry_prio = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_grant_valid;
   logic [aepq_pkg::IdW-1:0]     rsp_granted_id;
   logic [aepq_pkg::PrioW-1:0]   rsp_granted_prio;
   logic                         rsp_insert_dropped;
   logic [aepq_pkg::CntOutW-1:0] rsp_active_count;
   logic [aepq_pkg::CntOutW-1:0] rsp_expired_count;

   // predictor state: queue 0 and queue 1, front of each at index 0
   aepq_pkg::entry_type  run_q [2][DEPTH];
   int                   run_len [2] = '{0, 0};
   bit                   q0_active = 1'b1;

   // expected results in acceptance order
   sched_outcome_type    outcome_ring [RING_DEPTH];
   int                   ring_wr = 0;
   int                   ring_rd = 0;
   int                   mismatch_count = 0;
   int                   rsp_seen = 0;
   int                   cycle_count = 0;

   // shared between sender and receiver
   bit                   calm = 1'b0;
   bit                   quiet_tail = 1'b0;
   bit                   hold_rsp_long = 1'b0;

   // directed table: extremes, fifo order among equal priorities, the role
   // swap on an empty active queue, get with both queues empty, unused type
   stim_row_type directed_rows [0:23] = '{
      // get straight after reset: both queues empty, nothing granted
      '{aepq_pkg::REQ_GET, 8'h00, 4'h0, 1'b1,
        {1'b0, 8'h00, 4'h0, 1'b0, 7'd0, 7'd0}},
      // unused request: only counts come back
      '{aepq_pkg::REQ_UNUSED, 8'hff, 4'hf, 1'b1,
        {1'b0, 8'h00, 4'h0, 1'b0, 7'd0, 7'd0}},
      // field extremes into the active queue
      '{aepq_pkg::REQ_INS_ACTIVE, 8'hff, 4'hf, 1'b1,
        {1'b0, 8'h00, 4'h0, 1'b0, 7'd1, 7'd0}},
      '{aepq_pkg::REQ_INS_ACTIVE, 8'h00, 4'h0, 1'b1,
        {1'b0, 8'h00, 4'h0, 1'b0, 7'd2, 7'd0}},
      // equal priorities must stay in arrival order
      '{aepq_pkg::REQ_INS_ACTIVE,  8'h11, 4'h7, 1'b0, '0},
      '{aepq_pkg::REQ_INS_ACTIVE,  8'h12, 4'h7, 1'b0, '0},
      '{aepq_pkg::REQ_INS_ACTIVE,  8'h13, 4'hf, 1'b0, '0},
      '{aepq_pkg::REQ_INS_EXPIRED, 8'ha5, 4'h5, 1'b0, '0},
      '{aepq_pkg::REQ_INS_EXPIRED, 8'h5a, 4'ha, 1'b0, '0},
      '{aepq_pkg::REQ_INS_EXPIRED, 8'h5b, 4'ha, 1'b0, '0},
      '{aepq_pkg::REQ_UNUSED,      8'h3c, 4'h3, 1'b0, '0},
      // drain the active queue
      '{aepq_pkg::REQ_GET,         8'h00, 4'h0, 1'b0, '0},
      '{aepq_pkg::REQ_GET,         8'h00, 4'h0, 1'b0, '0},
      '{aepq_pkg::REQ_GET,         8'h00, 4'h0, 1'b0, '0},
      '{aepq_pkg::REQ_GET,         8'h00, 4'h0, 1'b0, '0},
      '{aepq_pkg::REQ_GET,         8'h00, 4'h0, 1'b0, '0},
      // active empty: roles swap, then pop
      '{aepq_pkg::REQ_GET,         8'h00, 4'h0, 1'b0, '0},
      '{aepq_pkg::REQ_INS_EXPIRED, 8'h01, 4'h8, 1'b0, '0},
      '{aepq_pkg::REQ_GET,         8'h00, 4'h0, 1'b0, '0},
      '{aepq_pkg::REQ_GET,         8'h00, 4'h0, 1'b0, '0},
      // second swap, back to the first queue
      '{aepq_pkg::REQ_GET,         8'h00, 4'h0, 1'b0, '0},
      // both queues empty again
      '{aepq_pkg::REQ_GET, 8'h00, 4'h0, 1'b1,
        {1'b0, 8'h00, 4'h0, 1'b0, 7'd0, 7'd0}},
      '{aepq_pkg::REQ_INS_EXPIRED, 8'h80, 4'h1, 1'b0, '0},
      '{aepq_pkg::REQ_INS_ACTIVE,  8'h7f, 4'he, 1'b0, '0}
   };

   active_expired_priority_queue_top #(
      .DEPTH(DEPTH)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_process_id     (req_process_id),
      .req_entry_prio     (req_entry_prio),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_grant_valid    (rsp_grant_valid),
      .rsp_granted_id     (rsp_granted_id),
      .rsp_granted_prio   (rsp_granted_prio),
      .rsp_insert_dropped (rsp_insert_dropped),
      .rsp_active_count   (rsp_active_count),
      .rsp_expired_count  (rsp_expired_count)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  ring_wr - ring_rd);
         $display("active_expired_priority_queue_top test failed");
         $finish;
      end
   end

   task automatic note_mismatch(string what, int got, int want);
      $display("mismatch in result %0d: %s got %0d, want %0d", rsp_seen, what, got, want);
      mismatch_count++;
   endtask

   // next state and result of the run queue pair for one accepted request
   function automatic sched_outcome_type predict_outcome(aepq_pkg::req_code_type rt,
                                                         aepq_pkg::entry_type ent);
      sched_outcome_type res;
      int act, tgt, pos, i;
      res = '0;
      act = q0_active ? 0 : 1;
      // a get on an empty active queue swaps roles first, unless both are empty
      if (rt == aepq_pkg::REQ_GET && run_len[act] == 0 && run_len[1 - act] != 0) begin
         q0_active = !q0_active;
         act = 1 - act;
      end
      if (rt == aepq_pkg::REQ_INS_ACTIVE || rt == aepq_pkg::REQ_INS_EXPIRED) begin
         tgt = (rt == aepq_pkg::REQ_INS_ACTIVE) ? act : 1 - act;
         if (run_len[tgt] >= DEPTH) begin
            res.dropped = 1'b1;
         end else begin
            // ahead of the first strictly lower priority, else at the back
            pos = run_len[tgt];
            for (i = run_len[tgt] - 1; i >= 0; i--)
               if (run_q[tgt][i].prio < ent.prio) pos = i;
            for (i = run_len[tgt]; i > pos; i--)
               run_q[tgt][i] = run_q[tgt][i - 1];
            run_q[tgt][pos] = ent;
            run_len[tgt]++;
         end
      end else if (rt == aepq_pkg::REQ_GET && run_len[act] != 0) begin
         res.grant = 1'b1;
         res.id    = run_q[act][0].id;
         res.prio  = run_q[act][0].prio;
         for (i = 1; i < run_len[act]; i++)
            run_q[act][i - 1] = run_q[act][i];
         run_len[act]--;
      end
      res.act_cnt = aepq_pkg::CntOutW'(run_len[act]);
      res.exp_cnt = aepq_pkg::CntOutW'(run_len[1 - act]);
      return res;
   endfunction

   // offer one request, wait for it to be taken, queue its expected result
   task automatic offer_request(aepq_pkg::req_code_type rt,
                                logic [aepq_pkg::IdW-1:0] id,
                                logic [aepq_pkg::PrioW-1:0] prio, logic typed,
                                sched_outcome_type typed_want);
      sched_outcome_type want;
      aepq_pkg::entry_type ent;
      req_valid      <= 1'b1;
      req_type       <= rt;
      req_process_id <= id;
      req_entry_prio <= prio;
      do @(posedge clock); while (!req_ready);
      ent.id   = id;
      ent.prio = prio;
      want = predict_outcome(rt, ent);
      outcome_ring[ring_wr % RING_DEPTH] = typed ? typed_want : want;
      ring_wr++;
      // random gap before the next request
      if (!calm && !quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // result side: random back-pressure bursts, one long hold on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_long) begin
            hold_rsp_long = 1'b0;
            hold_left = LONG_HOLD;
         end else if (hold_left == 0 && !calm && !quiet_tail && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 7);
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // result checker: each accepted result against the oldest expectation
   always @(posedge clock) begin : rsp_check
      sched_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (ring_wr == ring_rd) begin
            note_mismatch("result with nothing pending", 1, 0);
         end else begin
            want = outcome_ring[ring_rd % RING_DEPTH];
            ring_rd++;
            if (rsp_grant_valid !== want.grant)
               note_mismatch("grant_valid", rsp_grant_valid, want.grant);
            if (rsp_granted_id !== want.id)
               note_mismatch("granted_id", rsp_granted_id, want.id);
            if (rsp_granted_prio !== want.prio)
               note_mismatch("granted_prio", rsp_granted_prio, want.prio);
            if (rsp_insert_dropped !== want.dropped)
               note_mismatch("insert_dropped", rsp_insert_dropped, want.dropped);
            if (rsp_active_count !== want.act_cnt)
               note_mismatch("active_count", rsp_active_count, want.act_cnt);
            if (rsp_expired_count !== want.exp_cnt)
               note_mismatch("expired_count", rsp_expired_count, want.exp_cnt);
         end
         rsp_seen++;
      end
   end

   // request side: directed table, then random bursts
   initial begin : req_side
      int k, burst, sent, len, r, extra;
      aepq_pkg::req_code_type rt;
      sent = 0;
      burst = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < $size(directed_rows); k++)
         offer_request(directed_rows[k].rt, directed_rows[k].id, directed_rows[k].prio,
                       directed_rows[k].typed, directed_rows[k].want);

      while (sent < RANDOM_REQS) begin
         burst++;
         calm = ($urandom_range(0, 3) == 0);
         quiet_tail = (sent >= TAIL_START);
         // hold the result side off while the active queue floods
         if (burst == 3) hold_rsp_long = 1'b1;
         // let everything drain before the fourth burst
         if (burst == 4) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (ring_wr != ring_rd);
         end
         r = $urandom_range(0, 99);
         if (burst == 1 || burst == 3 || (burst > 4 && r < 15)) begin
            // flood one queue until it is full, then a few dropped inserts
            if (burst == 1)      rt = aepq_pkg::REQ_INS_EXPIRED;
            else if (burst == 3) rt = aepq_pkg::REQ_INS_ACTIVE;
            else rt = $urandom_range(0, 1) ? aepq_pkg::REQ_INS_ACTIVE
                                           : aepq_pkg::REQ_INS_EXPIRED;
            extra = $urandom_range(1, 4);
            while (extra > 0) begin
               if (run_len[(rt == aepq_pkg::REQ_INS_ACTIVE) == q0_active ? 0 : 1] >= DEPTH)
                  extra--;
               offer_request(rt, aepq_pkg::IdW'($urandom_range(0, 255)),
                             aepq_pkg::PrioW'($urandom_range(0, 15)), 1'b0, '0);
               sent++;
            end
         end else if (r < 40) begin
            // drain through swaps until both queues are empty or 80 gets are sent
            len = 0;
            while (run_len[0] + run_len[1] != 0 && len < 80) begin
               offer_request(aepq_pkg::REQ_GET, aepq_pkg::IdW'($urandom_range(0, 255)),
                             aepq_pkg::PrioW'($urandom_range(0, 15)), 1'b0, '0);
               len++;
               sent++;
            end
            repeat ($urandom_range(1, 2)) begin
               offer_request(aepq_pkg::REQ_GET, '0, '0, 1'b0, '0);
               sent++;
            end
         end else begin
            // mixed traffic with the odd unused request
            len = $urandom_range(10, 30);
            for (k = 0; k < len; k++) begin
               r = $urandom_range(0, 99);
               if (r < 40)      rt = aepq_pkg::REQ_INS_ACTIVE;
               else if (r < 65) rt = aepq_pkg::REQ_INS_EXPIRED;
               else if (r < 95) rt = aepq_pkg::REQ_GET;
               else             rt = aepq_pkg::REQ_UNUSED;
               offer_request(rt, aepq_pkg::IdW'($urandom_range(0, 255)),
                             aepq_pkg::PrioW'($urandom_range(0, 15)), 1'b0, '0);
               if (rt != aepq_pkg::REQ_UNUSED) sent++;
            end
         end
      end

      req_valid <= 1'b0;
      while (ring_wr != ring_rd) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("active_expired_priority_queue_top test passed");
      end else begin
         $display("active_expired_priority_queue_top test failed");
      end
      $finish;
   end

endmodule
